// File: rtl/core/til_pkg.sv
// Shared types, constants and helpers for the tensor index linearizer.
`timescale 1ns / 1ps
package til_pkg;

    localparam int MAX_RANK    = 5;
    localparam int EXT_W       = 16;
    localparam int LIN_W       = 32;
    localparam int SAT_W       = LIN_W + 1;
    localparam int PROD_W      = LIN_W + EXT_W;
    localparam int DIM_W       = 3;
    localparam int PERM_W      = DIM_W * MAX_RANK;
    localparam int BITS_STEP   = 2;
    localparam int GROUP_STEPS = LIN_W / BITS_STEP;
    localparam int NUM_STAGES  = MAX_RANK * GROUP_STEPS;
    localparam int CFG_IDX_W   = 3;

    localparam logic [SAT_W-1:0] CAP = {1'b1, {LIN_W{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_ORDER_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_RANK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_PERM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0     = 3'd3;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_RANK  = 2'd1,
        ST_MISMATCH   = 2'd2,
        ST_OUT_RANGE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [DIM_W-1:0]              order_length;
        logic [DIM_W-1:0]              shape_rank;
        logic [PERM_W-1:0]             order_perm;
        logic [MAX_RANK-1:0][EXT_W-1:0] extent;
    } cfg_t;

    typedef struct packed {
        logic                           mode;
        status_t                        status;
        logic                           oor;
        logic [LIN_W-1:0]               dq;
        logic [EXT_W-1:0]               r;
        logic [MAX_RANK-1:0][EXT_W-1:0] subs;
        logic [LIN_W-1:0]               low;
        logic [SAT_W-1:0]               res_sat;
        logic [LIN_W-1:0]               mul_low;
        logic [SAT_W-1:0]               mul_sat;
        logic [PROD_W-1:0]              p;
        logic [PROD_W-1:0]              q;
    } item_t;

    function automatic logic [DIM_W-1:0] perm_at(input logic [PERM_W-1:0] perm,
                                                 input logic [DIM_W-1:0] k);
        logic [DIM_W*8-1:0] wide;
        wide = {{(DIM_W*8-PERM_W){1'b0}}, perm};
        return wide[DIM_W*k +: DIM_W];
    endfunction

    function automatic status_t check_shape(input cfg_t cfg);
        status_t st;
        st = ST_OK;
        if (cfg.shape_rank == '0)
        begin
            st = ST_ZERO_RANK;
        end
        else if (cfg.shape_rank != cfg.order_length || cfg.shape_rank > DIM_W'(MAX_RANK))
        begin
            st = ST_MISMATCH;
        end
        else
        begin
            for (int k = 0; k < MAX_RANK; k++)
            begin
                if (DIM_W'(k) < cfg.order_length &&
                    perm_at(cfg.order_perm, DIM_W'(k)) >= cfg.shape_rank)
                begin
                    st = ST_MISMATCH;
                end
            end
        end
        return st;
    endfunction

endpackage

// File: rtl/core/til_if.sv
// Item channel interfaces for the tensor index linearizer.
`timescale 1ns / 1ps
interface til_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] linear_in;
    logic [15:0] subscript_0;
    logic [15:0] subscript_1;
    logic [15:0] subscript_2;
    logic [15:0] subscript_3;
    logic [15:0] subscript_4;
    modport source (output valid, mode, linear_in, subscript_0, subscript_1, subscript_2,
                    subscript_3, subscript_4, input ready);
    modport sink (input valid, mode, linear_in, subscript_0, subscript_1, subscript_2,
                  subscript_3, subscript_4, output ready);
endinterface

interface til_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] linear_out;
    logic [15:0] sub_out_0;
    logic [15:0] sub_out_1;
    logic [15:0] sub_out_2;
    logic [15:0] sub_out_3;
    logic [15:0] sub_out_4;
    logic [1:0]  status;
    logic        index_overflow;
    modport source (output valid, linear_out, sub_out_0, sub_out_1, sub_out_2, sub_out_3,
                    sub_out_4, status, index_overflow, input ready);
    modport sink (input valid, linear_out, sub_out_0, sub_out_1, sub_out_2, sub_out_3,
                  sub_out_4, status, index_overflow, output ready);
endinterface

// File: rtl/core/til_stage.sv
// One pipeline stage: two divider steps, plus the mode 0 multiply or accumulate.
`timescale 1ns / 1ps
module til_stage #(
    parameter int GROUP = 0,
    parameter int STEP  = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  til_pkg::cfg_t cfg,
    input  logic          valid_in,
    input  til_pkg::item_t item_in,
    output logic          valid_out,
    output til_pkg::item_t item_out
);
    import til_pkg::*;

    logic             valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic             active;
    logic [DIM_W-1:0] kpos;
    logic [DIM_W-1:0] dsel;
    logic             dim_ok;
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] sub;
    logic             m0;
    logic             m1;
    logic             div_en;
    logic [EXT_W:0]   rt;
    logic [SAT_W-1:0] term;
    logic [SAT_W:0]   acc;

    always_comb
    begin
        active = DIM_W'(GROUP) < cfg.order_length;
        kpos   = cfg.order_length - DIM_W'(1) - DIM_W'(GROUP);
        dsel   = perm_at(cfg.order_perm, kpos);
        dim_ok = dsel < DIM_W'(MAX_RANK);
        ext    = dim_ok ? cfg.extent[dsel] : '0;
        sub    = dim_ok ? item_in.subs[dsel] : '0;
        m0     = active && !item_in.mode;
        m1     = active && item_in.mode && dim_ok;
        div_en = m1 && (ext != '0);
        item_next = item_in;
        rt   = '0;
        term = '0;
        acc  = '0;

        if (STEP == 0)
        begin
            item_next.r = '0;
            if (m0)
            begin
                item_next.p = PROD_W'(item_in.mul_low) * PROD_W'(sub);
                item_next.q = PROD_W'(item_in.mul_low) * PROD_W'(ext);
                if (sub >= ext)
                begin
                    item_next.oor = 1'b1;
                end
            end
        end

        if (STEP == 1 && m0)
        begin
            item_next.low = item_in.low + item_in.p[LIN_W-1:0];
            if (item_in.mul_sat == CAP)
            begin
                term = (sub != '0) ? CAP : '0;
            end
            else
            begin
                term = (item_in.p > PROD_W'(CAP)) ? CAP : item_in.p[SAT_W-1:0];
            end
            acc = {1'b0, item_in.res_sat} + {1'b0, term};
            item_next.res_sat = (acc > {1'b0, CAP}) ? CAP : acc[SAT_W-1:0];
            item_next.mul_low = item_in.q[LIN_W-1:0];
            if (item_in.mul_sat == CAP)
            begin
                item_next.mul_sat = (ext != '0) ? CAP : '0;
            end
            else
            begin
                item_next.mul_sat = (item_in.q > PROD_W'(CAP)) ? CAP : item_in.q[SAT_W-1:0];
            end
        end

        if (div_en)
        begin
            for (int b = 0; b < BITS_STEP; b++)
            begin
                rt = {item_next.r, item_next.dq[LIN_W-1]};
                item_next.dq = {item_next.dq[LIN_W-2:0], 1'b0};
                if (rt >= {1'b0, ext})
                begin
                    rt = rt - {1'b0, ext};
                    item_next.dq[0] = 1'b1;
                end
                item_next.r = rt[EXT_W-1:0];
            end
        end

        if (STEP == GROUP_STEPS - 1 && m1)
        begin
            item_next.subs[dsel] = div_en ? item_next.r : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

// File: rtl/core/tensor_index_linearizer_top.sv
// Top level of the tensor index linearizer: config registers, stage chain, output register.
`timescale 1ns / 1ps
// Converts subscripts to a linear index (mode 0) or a linear index to subscripts (mode 1)
// for a tensor of up to five dimensions. One item enters per cycle unless stalled;
// each result passes through five dimension groups of 16 stages and the output register,
// each stage resolving two quotient bits of a 32-by-16 restoring divide (mode 0 uses the
// first two stages of each group for its multiply and accumulate). A stalled output holds
// the whole chain. The user must write configuration only while idle (not enforced).
module tensor_index_linearizer_top (
    input  logic                       clk,
    input  logic                       rst_n,
    til_in_if.sink                     in_ch,
    til_out_if.source                  out_ch,
    input  logic                       cfg_we,
    input  logic [til_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [til_pkg::EXT_W-1:0]  cfg_data
);
    import til_pkg::*;

    cfg_t             cfg_reg;
    logic             ce;
    logic             pv   [0:NUM_STAGES];
    item_t            pipe [0:NUM_STAGES];
    logic             out_valid_reg;
    logic [LIN_W-1:0] linear_reg;
    logic [MAX_RANK-1:0][EXT_W-1:0] subs_reg;
    status_t          status_reg;
    logic             ovf_reg;
    item_t            last;
    status_t          fin_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order_length <= 3'd4;
            cfg_reg.shape_rank   <= 3'd4;
            cfg_reg.order_perm   <= 15'd18056;
            for (int d = 0; d < MAX_RANK; d++)
            begin
                cfg_reg.extent[d] <= EXT_W'(1);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORDER_LENGTH: cfg_reg.order_length <= cfg_data[DIM_W-1:0];
                REG_SHAPE_RANK:   cfg_reg.shape_rank   <= cfg_data[DIM_W-1:0];
                REG_ORDER_PERM:   cfg_reg.order_perm   <= cfg_data[PERM_W-1:0];
                default:
                begin
                    if (cfg_index >= REG_EXTENT_0 &&
                        (cfg_index - REG_EXTENT_0) < CFG_IDX_W'(MAX_RANK))
                    begin
                        cfg_reg.extent[cfg_index - REG_EXTENT_0] <= cfg_data;
                    end
                end
            endcase
        end
    end

    assign ce          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = ce;

    // mode 1 starts from all-zero subscripts so unlisted dimensions read as zero
    always_comb
    begin
        pv[0]           = in_ch.valid;
        pipe[0]         = '0;
        pipe[0].mode    = in_ch.mode;
        pipe[0].status  = check_shape(cfg_reg);
        pipe[0].dq      = in_ch.linear_in;
        pipe[0].subs[0] = in_ch.mode ? '0 : in_ch.subscript_0;
        pipe[0].subs[1] = in_ch.mode ? '0 : in_ch.subscript_1;
        pipe[0].subs[2] = in_ch.mode ? '0 : in_ch.subscript_2;
        pipe[0].subs[3] = in_ch.mode ? '0 : in_ch.subscript_3;
        pipe[0].subs[4] = in_ch.mode ? '0 : in_ch.subscript_4;
        pipe[0].mul_low = LIN_W'(1);
        pipe[0].mul_sat = SAT_W'(1);
    end

    for (genvar n = 0; n < NUM_STAGES; n++)
    begin : g_stage
        til_stage #(
            .GROUP(n / GROUP_STEPS),
            .STEP (n % GROUP_STEPS)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ce       (ce),
            .cfg      (cfg_reg),
            .valid_in (pv[n]),
            .item_in  (pipe[n]),
            .valid_out(pv[n+1]),
            .item_out (pipe[n+1])
        );
    end

    assign last       = pipe[NUM_STAGES];
    assign fin_status = (last.status == ST_OK && last.oor) ? ST_OUT_RANGE : last.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= pv[NUM_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            status_reg <= fin_status;
            linear_reg <= (fin_status == ST_OK && !last.mode) ? last.low : '0;
            ovf_reg    <= (fin_status == ST_OK && !last.mode) ? last.res_sat[LIN_W] : 1'b0;
            subs_reg   <= (fin_status == ST_OK && last.mode) ? last.subs : '0;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.linear_out     = linear_reg;
    assign out_ch.sub_out_0      = subs_reg[0];
    assign out_ch.sub_out_1      = subs_reg[1];
    assign out_ch.sub_out_2      = subs_reg[2];
    assign out_ch.sub_out_3      = subs_reg[3];
    assign out_ch.sub_out_4      = subs_reg[4];
    assign out_ch.status         = status_reg;
    assign out_ch.index_overflow = ovf_reg;

endmodule

// File: rtl/core/til_checker.sv
// Port-level assertions for the tensor index linearizer, bound to the top level.
`timescale 1ns / 1ps
module til_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] linear_out,
    input logic [15:0] sub_out_0,
    input logic [15:0] sub_out_1,
    input logic [15:0] sub_out_2,
    input logic [15:0] sub_out_3,
    input logic [15:0] sub_out_4,
    input logic [1:0]  status,
    input logic        index_overflow
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(linear_out) && $stable(status))
        else $error("result dropped or changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output slot");

    a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (linear_out == 32'd0 && !index_overflow) ||
        (sub_out_0 == 16'd0 && sub_out_1 == 16'd0 && sub_out_2 == 16'd0 &&
         sub_out_3 == 16'd0 && sub_out_4 == 16'd0))
        else $error("both index and subscripts nonzero");

    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'd0 |-> linear_out == 32'd0 && !index_overflow)
        else $error("error result carries data");

endmodule

bind tensor_index_linearizer_top til_checker u_til_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .linear_out    (out_ch.linear_out),
    .sub_out_0     (out_ch.sub_out_0),
    .sub_out_1     (out_ch.sub_out_1),
    .sub_out_2     (out_ch.sub_out_2),
    .sub_out_3     (out_ch.sub_out_3),
    .sub_out_4     (out_ch.sub_out_4),
    .status        (out_ch.status),
    .index_overflow(out_ch.index_overflow)
);
